// ===== src/refcounted_handle_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the reference-counted handle tracker
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_TRACKER_TOP_MACROS_SVH
`define REFCOUNTED_HANDLE_TRACKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds at every clock edge
`define RHT_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define RHT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RHT_ASSERT_HOLDS(lbl, expr, msg)
`define RHT_ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

// ===== src/rht_pkg.sv =====
// ----------------------------------------------------------------------------
// Handle tracker package
// Operation and status codes, and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int HANDLE_W   = 32;
    localparam int COUNT_W    = 16;
    localparam int AMOUNT_W   = 16;

    // Operation codes on the func field
    localparam logic [FUNC_W-1:0] FN_GET   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INC   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEC   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SUB   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT     = 2'd3;

    // Count update applied by the read-modify-write step
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INC,
        OP_SUB1,
        OP_SUBN
    } t_op;

    typedef struct packed {
        logic capture;    // load the input item
        logic sel_cur;    // point the work slot at the current entry
        logic flag_nf;    // report handle not found
        logic find;       // search the table, insert on miss for set
        logic modify;     // update the count of the work slot
        t_op  op;
        logic make_cur;   // work slot becomes current
        logic clear_cur;  // drop the current mark
        logic emit;       // load the result item
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              in_zero;
        logic              cur_valid;
        logic              cur_same;
        logic              add_ref;
        logic              hit;
        logic              free_avail;
        logic              out_busy;
    } t_stat;

endpackage

// ===== src/refcounted_handle_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Reference-counted handle tracker
// Items run from prepare to output; a set that replaces a current entry takes
// the longest path (prepare, drop, find, modify, out); a new item waits for
// the last to be emitted. The controller steps one phase per cycle, held in
// out while the result stalls, over the single count read-modify-write path.
// Reset: synchronous, active low; clears slot use bits, the current entry and
// result valid directly, with no clearing pass over the table.
// ----------------------------------------------------------------------------
module refcounted_handle_tracker_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 16,
    parameter int HANDLE_BITS   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [rht_pkg::FUNC_W-1:0]   i_func,
    input  logic [rht_pkg::HANDLE_W-1:0] i_handle,
    input  logic                         i_add_reference,
    input  logic [rht_pkg::AMOUNT_W-1:0] i_amount,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rht_pkg::STATUS_W-1:0] o_status,
    output logic [rht_pkg::HANDLE_W-1:0] o_current_handle,
    output logic                         o_current_present,
    output logic                         o_released,
    output logic [rht_pkg::HANDLE_W-1:0] o_released_handle,
    output logic [rht_pkg::COUNT_W-1:0]  o_result_count
);

    rht_pkg::t_cmd  cmd;
    rht_pkg::t_stat stat;

    // Sequence each item
    rht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Hold the table and build the result
    rht_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_func            (i_func),
        .i_handle          (i_handle),
        .i_add_reference   (i_add_reference),
        .i_amount          (i_amount),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_current_handle  (o_current_handle),
        .o_current_present (o_current_present),
        .o_released        (o_released),
        .o_released_handle (o_released_handle),
        .o_result_count    (o_result_count)
    );

endmodule

// ===== src/rht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Handle tracker controller
// Steps items from prepare to output via drop, find and modify as needed.
// ----------------------------------------------------------------------------
module rht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rht_pkg::t_stat i_stat,
    output logic          o_stall,
    output rht_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DROP,
        S_FIND,
        S_MOD,
        S_OUT
    } t_state;

    t_state       r_state, n_state;
    rht_pkg::t_op r_op, n_op;
    logic         r_make_cur, n_make_cur;
    logic         r_clear_cur, n_clear_cur;

    // Take a new item only between sequences
    assign o_stall = (r_state != S_IDLE);

    // Decode the next step and the commands of this one
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_make_cur  = r_make_cur;
        n_clear_cur = r_clear_cur;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = rht_pkg::OP_NONE;
                    n_make_cur    = 1'b0;
                    n_clear_cur   = 1'b0;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_OUT;
                unique case (i_stat.func) inside
                    rht_pkg::FN_GET: begin
                        if (i_stat.cur_valid) begin
                            o_cmd.sel_cur = 1'b1;
                            n_op    = i_stat.add_ref ? rht_pkg::OP_INC : rht_pkg::OP_NONE;
                            n_state = S_MOD;
                        end
                    end
                    rht_pkg::FN_SET: begin
                        if (i_stat.in_zero) begin
                            o_cmd.flag_nf = 1'b1;
                        end else if (i_stat.cur_same) begin
                            o_cmd.sel_cur = 1'b1;
                            n_op    = rht_pkg::OP_NONE;
                            n_state = S_MOD;
                        end else if (i_stat.cur_valid) begin
                            o_cmd.sel_cur = 1'b1;
                            n_state = S_DROP;
                        end else begin
                            n_state = S_FIND;
                        end
                    end
                    rht_pkg::FN_CLEAR: begin
                        if (i_stat.cur_valid) begin
                            o_cmd.sel_cur = 1'b1;
                            n_op        = rht_pkg::OP_SUB1;
                            n_clear_cur = 1'b1;
                            n_state     = S_MOD;
                        end
                    end
                    rht_pkg::FN_INC, rht_pkg::FN_DEC, rht_pkg::FN_SUB: begin
                        n_state = S_FIND;
                    end
                    default: begin
                    end
                endcase
            end
            S_DROP: begin
                // Release the old current entry's reference before the search
                o_cmd.modify    = 1'b1;
                o_cmd.op        = rht_pkg::OP_SUB1;
                o_cmd.clear_cur = 1'b1;
                n_state         = S_FIND;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = S_OUT;
                if (i_stat.hit || (i_stat.func == rht_pkg::FN_SET && i_stat.free_avail)) begin
                    n_state = S_MOD;
                    unique case (i_stat.func)
                        rht_pkg::FN_SET: begin
                            n_op       = rht_pkg::OP_INC;
                            n_make_cur = 1'b1;
                        end
                        rht_pkg::FN_INC: n_op = rht_pkg::OP_INC;
                        rht_pkg::FN_DEC: n_op = rht_pkg::OP_SUB1;
                        default:         n_op = rht_pkg::OP_SUBN;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.modify    = 1'b1;
                o_cmd.op        = r_op;
                o_cmd.make_cur  = r_make_cur;
                o_cmd.clear_cur = r_clear_cur;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered step controls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= rht_pkg::OP_NONE;
            r_make_cur  <= 1'b0;
            r_clear_cur <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_make_cur  <= n_make_cur;
            r_clear_cur <= n_clear_cur;
        end
    end

endmodule

// ===== src/rht_datapath.sv =====
// ----------------------------------------------------------------------------
// Handle tracker datapath
// Handle table with parallel lookup, one count read-modify-write per cycle,
// the current entry mark and the result register.
// ----------------------------------------------------------------------------
`include "refcounted_handle_tracker_top_macros.svh"

module rht_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 16,
    parameter int HANDLE_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rht_pkg::t_cmd                   i_cmd,
    output rht_pkg::t_stat                  o_stat,
    input  logic [rht_pkg::FUNC_W-1:0]      i_func,
    input  logic [rht_pkg::HANDLE_W-1:0]    i_handle,
    input  logic                            i_add_reference,
    input  logic [rht_pkg::AMOUNT_W-1:0]    i_amount,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [rht_pkg::STATUS_W-1:0]    o_status,
    output logic [rht_pkg::HANDLE_W-1:0]    o_current_handle,
    output logic                            o_current_present,
    output logic                            o_released,
    output logic [rht_pkg::HANDLE_W-1:0]    o_released_handle,
    output logic [rht_pkg::COUNT_W-1:0]     o_result_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int SW = (COUNT_BITS > rht_pkg::AMOUNT_W) ? COUNT_BITS : rht_pkg::AMOUNT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Captured item
    logic [rht_pkg::FUNC_W-1:0]   r_func;
    logic [HANDLE_BITS-1:0]       r_h;
    logic                         r_addref;
    logic [rht_pkg::AMOUNT_W-1:0] r_amount;

    // Table and current entry
    logic [TABLE_ENTRIES-1:0]     r_used;
    logic [HANDLE_BITS-1:0]       r_handle [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]        r_refs   [TABLE_ENTRIES];
    logic [IW-1:0]                r_cur_slot;
    logic                         r_cur_valid;
    logic [HANDLE_BITS-1:0]       r_cur_handle;

    // Work slot and pending result
    logic [IW-1:0]                r_slot;
    logic [rht_pkg::STATUS_W-1:0] r_status;
    logic [COUNT_BITS-1:0]        r_count;
    logic                         r_rel;
    logic [HANDLE_BITS-1:0]       r_rel_handle;
    logic                         r_out_valid;

    logic                         hit;
    logic [IW-1:0]                hit_slot;
    logic                         free_avail;
    logic [IW-1:0]                free_slot;
    logic                         do_insert;

    logic [COUNT_BITS-1:0]        refs_rd;
    logic [SW-1:0]                refs_wide;
    logic [SW-1:0]                sub_n;
    logic [COUNT_BITS-1:0]        refs_new;
    logic                         cnt_err;
    logic                         mod_free;

    // Search all entries; the lowest match and the lowest free slot win
    always_comb begin
        hit        = 1'b0;
        hit_slot   = '0;
        free_avail = 1'b0;
        free_slot  = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_used[i] && (r_handle[i] == r_h) && (r_h != '0)) begin
                hit      = 1'b1;
                hit_slot = IW'(i);
            end
            if (!r_used[i]) begin
                free_avail = 1'b1;
                free_slot  = IW'(i);
            end
        end
    end

    assign do_insert = !hit && free_avail && (r_func == rht_pkg::FN_SET);

    // Compute the updated count of the work slot, saturating both ways
    always_comb begin
        refs_rd   = r_refs[r_slot];
        refs_wide = SW'(refs_rd);
        sub_n     = (i_cmd.op == rht_pkg::OP_SUB1) ? SW'(1) : SW'(r_amount);
        refs_new  = refs_rd;
        cnt_err   = 1'b0;
        mod_free  = 1'b0;
        case (i_cmd.op)
            rht_pkg::OP_INC: begin
                if (refs_rd == COUNT_MAX) begin
                    cnt_err = 1'b1;
                end else begin
                    refs_new = refs_rd + COUNT_BITS'(1);
                end
            end
            rht_pkg::OP_SUB1, rht_pkg::OP_SUBN: begin
                if (sub_n > refs_wide) begin
                    cnt_err  = 1'b1;
                    refs_new = '0;
                end else begin
                    refs_new = COUNT_BITS'(refs_wide - sub_n);
                end
                mod_free = (refs_new == '0);
            end
            default: begin
            end
        endcase
    end

    // Report to the controller
    always_comb begin
        o_stat.func       = r_func;
        o_stat.in_zero    = (r_h == '0);
        o_stat.cur_valid  = r_cur_valid;
        o_stat.cur_same   = r_cur_valid && (r_cur_handle == r_h);
        o_stat.add_ref    = r_addref;
        o_stat.hit        = hit;
        o_stat.free_avail = free_avail;
        o_stat.out_busy   = r_out_valid && i_stall;
    end

    // Update slot occupancy, the current mark and the result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_cur_valid <= 1'b0;
            r_cur_slot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.find && do_insert) begin
                r_used[free_slot] <= 1'b1;
            end
            if (i_cmd.modify) begin
                if (mod_free) begin
                    r_used[r_slot] <= 1'b0;
                end
                if (i_cmd.clear_cur || (mod_free && r_cur_slot == r_slot)) begin
                    r_cur_valid <= 1'b0;
                end
                if (i_cmd.make_cur) begin
                    r_cur_slot  <= r_slot;
                    r_cur_valid <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Advance item payload, table contents and the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func       <= i_func;
            r_h          <= HANDLE_BITS'(64'(i_handle));
            r_addref     <= i_add_reference;
            r_amount     <= i_amount;
            r_status     <= rht_pkg::ST_OK;
            r_count      <= '0;
            r_rel        <= 1'b0;
            r_rel_handle <= '0;
        end
        if (i_cmd.sel_cur) begin
            r_slot <= r_cur_slot;
        end
        if (i_cmd.flag_nf) begin
            r_status <= rht_pkg::ST_NOT_FOUND;
        end
        if (i_cmd.find) begin
            if (hit) begin
                r_slot <= hit_slot;
            end else if (do_insert) begin
                r_slot              <= free_slot;
                r_handle[free_slot] <= r_h;
                r_refs[free_slot]   <= '0;
            end else begin
                r_count  <= '0;
                r_status <= (r_func == rht_pkg::FN_SET) ? rht_pkg::ST_FULL
                                                        : rht_pkg::ST_NOT_FOUND;
            end
        end
        if (i_cmd.modify) begin
            r_refs[r_slot] <= refs_new;
            r_count        <= mod_free ? '0 : refs_new;
            if (cnt_err) begin
                r_status <= rht_pkg::ST_COUNT;
            end
            if (mod_free) begin
                r_rel        <= 1'b1;
                r_rel_handle <= r_handle[r_slot];
            end
            if (i_cmd.make_cur) begin
                r_cur_handle <= r_h;
            end
        end
        if (i_cmd.emit) begin
            o_status          <= r_status;
            o_current_handle  <= r_cur_valid ? rht_pkg::HANDLE_W'(r_cur_handle) : '0;
            o_current_present <= r_cur_valid;
            o_released        <= r_rel;
            o_released_handle <= r_rel ? rht_pkg::HANDLE_W'(r_rel_handle) : '0;
            o_result_count    <= rht_pkg::COUNT_W'(r_count);
        end
    end

    assign o_valid = r_out_valid;

    // The current mark names a live, mirrored entry; a stalled result is kept
    `RHT_ASSERT_IMPLIES(a_cur_used, r_cur_valid, r_used[r_cur_slot], "current entry not in use")
    `RHT_ASSERT_IMPLIES(a_cur_handle, r_cur_valid,
                        r_handle[r_cur_slot] == r_cur_handle, "current handle copy stale")
    `RHT_ASSERT_HOLDS(a_emit_free, !(i_cmd.emit && r_out_valid && i_stall),
                      "result overwritten while stalled")

endmodule
